>>> hw/rtl/fps_pkg.sv
// shared constants and types of the five-point stencil stream
package fps_pkg;

   localparam int MAX_DIM = 2048;
   localparam int ADDR_W  = $clog2(MAX_DIM);
   localparam int DIM_W   = 12;
   localparam int DATA_W  = 32;
   localparam int TOTAL_W = 64;
   localparam int SUM_W   = DATA_W + 4;

   // register index, taken from paddr[2]
   localparam logic CSR_IDX_GRID_DIM = 1'b0;
   localparam logic [DIM_W-1:0] GRID_DIM_RESET = DIM_W'(MAX_DIM);
   localparam logic [DIM_W-1:0] GRID_DIM_MIN   = DIM_W'(8);

   typedef struct packed {
      logic interior;
      logic boundary;
      logic last_pos;
   } flags_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] up;
      logic signed [DATA_W-1:0] down;
      logic signed [DATA_W-1:0] left;
      logic signed [DATA_W-1:0] right;
      logic signed [DATA_W-1:0] ctr;
   } window_type;

endpackage

>>> hw/rtl/five_point_stencil_stream.sv
// five-point stencil over a raster-order grid, with line stores in two rams
// a word's results pass through stage 1, stage 2 and the output register on their way to rsp
// throughput: one req word per cycle while stage 2 and rsp are not stalled; on the last row each
//   interior column yields two rsp words, so the output port is the limit there
// reset: synchronous, active high; counters, totals and valid flags clear, grid_dim
//   returns to 2048; line stores are not cleared (only read after being written)
module five_point_stencil_stream
   import fps_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   // input stream
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,   // [31:0] sample
   // result stream
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [119:0]  rsp_tdata,   // [10:0] out_row, [21:11] out_col, [53:22] value,
                                      // [117:54] grand_total, [119:118] zero
   output logic          rsp_tlast,   // run_last
   output logic          rsp_tuser,   // frame_done
   // register port
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [2:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   // ---------------------------------------------------------------- config
   logic [DIM_W-1:0]  dim_ff, dim_in;
   logic [ADDR_W-1:0] last_idx;     // effective grid size minus one
   logic [DIM_W-1:0]  dim_m1;
   logic              csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel & csr_penable & csr_pwrite & csr_pready
                 & (csr_paddr[2] == CSR_IDX_GRID_DIM);
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_GRID_DIM) ? 32'(dim_ff) : '0;

   always_comb begin
      dim_in = csr_wr ? csr_pwdata[DIM_W-1:0] : dim_ff;
      dim_m1 = dim_ff - DIM_W'(1);
      // clamp the programmed size to 8..MAX_DIM
      if (dim_ff < GRID_DIM_MIN) begin
         last_idx = ADDR_W'(GRID_DIM_MIN - DIM_W'(1));
      end else if (dim_ff > DIM_W'(MAX_DIM)) begin
         last_idx = ADDR_W'(MAX_DIM - 1);
      end else begin
         last_idx = dim_m1[ADDR_W-1:0];
      end
   end

   // ---------------------------------------------------------------- input side
   // row/col point at the next sample; sel names the ram holding row r-1
   logic [ADDR_W-1:0] row_ff, row_in, col_ff, col_in, col_p1;
   logic              sel_ff, sel_in;
   logic [DATA_W-1:0] c0_ff, c0_in;   // column 0 sample of the current row
   logic              req_acc;
   logic              last_col, last_row;
   flags_type         acc_flags;

   assign req_acc  = req_tvalid & req_tready;
   assign col_p1   = col_ff + ADDR_W'(1);
   assign last_col = (col_ff == last_idx);
   assign last_row = (row_ff == last_idx);

   always_comb begin
      acc_flags.interior = (row_ff >= ADDR_W'(2)) && (col_ff != '0) && !last_col;
      acc_flags.boundary = (row_ff == '0) || last_row || (col_ff == '0) || last_col;
      acc_flags.last_pos = last_row && last_col;
   end

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      sel_in = sel_ff;
      c0_in  = c0_ff;
      if (csr_wr) begin
         // a size write restarts the frame, stores and select stay
         row_in = '0;
         col_in = '0;
      end else if (req_acc) begin
         if (col_ff == '0) begin
            c0_in = req_tdata;
         end
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + ADDR_W'(1);
            sel_in = ~sel_ff;
         end else begin
            col_in = col_p1;
         end
      end
   end

   // ---------------------------------------------------------------- line stores
   // newer ram is read one column ahead, older ram is read and overwritten at col
   logic [ADDR_W-1:0] a_rd_addr, b_rd_addr;
   logic [DATA_W-1:0] a_rd_data, b_rd_data;

   assign a_rd_addr = sel_ff ? col_ff : col_p1;
   assign b_rd_addr = sel_ff ? col_p1 : col_ff;

   fps_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_DIM)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (req_acc & sel_ff),
      .wr_addr (col_ff),
      .wr_data (req_tdata),
      .rd_en   (req_acc),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   fps_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_DIM)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (req_acc & ~sel_ff),
      .wr_addr (col_ff),
      .wr_data (req_tdata),
      .rd_en   (req_acc),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   // ---------------------------------------------------------------- stage 1
   // word waits here for its ram reads; the window holds newer[c-1] and newer[c]
   logic              s1_valid_ff, s1_valid_in;
   logic [DATA_W-1:0] s1_sample_ff, s1_c0_ff;
   logic [ADDR_W-1:0] s1_row_ff, s1_col_ff;
   logic              s1_sel_ff;
   flags_type         s1_flags_ff;
   logic [DATA_W-1:0] w_m1_ff, w_m1_in, w_0_ff, w_0_in;
   logic [DATA_W-1:0] newer_rd, older_rd;
   logic              s1_adv;
   logic              s2_free;
   window_type        win;
   logic [DATA_W-1:0] stencil_val;

   assign s1_adv      = s1_valid_ff & s2_free;
   assign req_tready  = ~s1_valid_ff | s2_free;
   assign s1_valid_in = req_acc | (s1_valid_ff & ~s1_adv);
   assign newer_rd    = s1_sel_ff ? b_rd_data : a_rd_data;
   assign older_rd    = s1_sel_ff ? a_rd_data : b_rd_data;

   always_comb begin
      w_m1_in = w_m1_ff;
      w_0_in  = w_0_ff;
      if (s1_adv) begin
         // column 0 of row r-1 is never read ahead, it comes from its own register
         w_m1_in = (s1_col_ff == '0) ? s1_c0_ff : w_0_ff;
         w_0_in  = newer_rd;
      end
   end

   always_comb begin
      win.up    = older_rd;
      win.down  = s1_sample_ff;
      win.left  = w_m1_ff;
      win.right = newer_rd;
      win.ctr   = w_0_ff;
   end

   fps_calc u_calc (
      .win   (win),
      .value (stencil_val)
   );

   // ---------------------------------------------------------------- stage 2
   // one or two results leave from here, interior result first
   logic              s2_valid_ff, s2_valid_in;
   logic              s2_phase_ff, s2_phase_in;
   logic [DATA_W-1:0] s2_stencil_ff, s2_sample_ff;
   logic [ADDR_W-1:0] s2_row_ff, s2_col_ff;
   flags_type         s2_flags_ff;
   logic              out_free, emit, s2_done_now, two_first;
   logic              emit_last, emit_done;
   logic [ADDR_W-1:0] emit_row;
   logic [DATA_W-1:0] emit_val;

   assign out_free  = ~rsp_tvalid | rsp_tready;
   assign emit      = s2_valid_ff & out_free & (s2_flags_ff.interior | s2_flags_ff.boundary);
   assign two_first = s2_flags_ff.interior & s2_flags_ff.boundary & ~s2_phase_ff;

   always_comb begin
      if (s2_flags_ff.interior && !s2_phase_ff) begin
         emit_row  = s2_row_ff - ADDR_W'(1);
         emit_val  = s2_stencil_ff;
         emit_last = ~s2_flags_ff.boundary;
         emit_done = 1'b0;
      end else begin
         emit_row  = s2_row_ff;
         emit_val  = s2_sample_ff;
         emit_last = 1'b1;
         emit_done = s2_flags_ff.last_pos;
      end
   end

   // a word with no result (row 1 interior) drops out at once
   assign s2_done_now = s2_valid_ff
                      & ((~s2_flags_ff.interior & ~s2_flags_ff.boundary) | (emit & ~two_first));
   assign s2_free     = ~s2_valid_ff | s2_done_now;
   assign s2_valid_in = s1_adv | (s2_valid_ff & ~s2_done_now);

   always_comb begin
      s2_phase_in = s2_phase_ff;
      if (emit && two_first) begin
         s2_phase_in = 1'b1;
      end else if (s2_done_now) begin
         s2_phase_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------- output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]        out_row_ff, out_col_ff;
   logic [DATA_W-1:0]        out_val_ff;
   logic [TOTAL_W-1:0]       out_total_ff;
   logic                     out_last_ff, out_done_ff;
   logic [TOTAL_W-1:0]       total_ff, total_in, total_sum;

   assign total_sum    = total_ff + {{(TOTAL_W-DATA_W){emit_val[DATA_W-1]}}, emit_val};
   assign rsp_valid_in = emit | (rsp_valid_ff & ~rsp_tready);

   always_comb begin
      total_in = total_ff;
      if (csr_wr) begin
         total_in = '0;
      end else if (emit) begin
         // the grid's total goes out with its final result, then starts over
         total_in = emit_done ? '0 : total_sum;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, out_total_ff, out_val_ff, out_col_ff, out_row_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_done_ff;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff       <= GRID_DIM_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         sel_ff       <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s2_phase_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else begin
         dim_ff       <= dim_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         sel_ff       <= sel_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s2_phase_ff  <= s2_phase_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      c0_ff   <= c0_in;
      w_m1_ff <= w_m1_in;
      w_0_ff  <= w_0_in;
      if (req_acc) begin
         s1_sample_ff <= req_tdata;
         s1_c0_ff     <= c0_ff;
         s1_row_ff    <= row_ff;
         s1_col_ff    <= col_ff;
         s1_sel_ff    <= sel_ff;
         s1_flags_ff  <= acc_flags;
      end
      if (s1_adv) begin
         s2_stencil_ff <= stencil_val;
         s2_sample_ff  <= s1_sample_ff;
         s2_row_ff     <= s1_row_ff;
         s2_col_ff     <= s1_col_ff;
         s2_flags_ff   <= s1_flags_ff;
      end
      if (emit) begin
         out_row_ff   <= emit_row;
         out_col_ff   <= s2_col_ff;
         out_val_ff   <= emit_val;
         out_total_ff <= total_sum;
         out_last_ff  <= emit_last;
         out_done_ff  <= emit_done;
      end
   end

`ifndef SYNTHESIS
   // the frame's final word is always the last of its run
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame_done without run_last");

   // running total starts over after the final result of a grid
   a_total_clear: assert property (@(posedge clock) disable iff (reset)
      emit && emit_done |=> total_ff == '0)
      else $error("running total not cleared at frame end");

   // column and row counters never pass the last index of the effective grid
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= last_idx && row_ff <= last_idx)
      else $error("position counter out of range");

   // second-result phase only for a word that carries two results
   a_phase_pair: assert property (@(posedge clock) disable iff (reset)
      s2_phase_ff |-> s2_valid_ff && s2_flags_ff.interior && s2_flags_ff.boundary)
      else $error("second-result phase on a single-result word");
`endif

endmodule

>>> hw/rtl/fps_ram.sv
// generic single-write, single-read ram with registered read (read-first)
module fps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/fps_calc.sv
// stencil arithmetic: quarter of neighbor sum minus center, rounded and saturated
module fps_calc
   import fps_pkg::*;
(
   input  window_type               win,
   output logic signed [DATA_W-1:0] value
);

   logic signed [SUM_W-1:0] total;
   logic signed [SUM_W-1:0] quot;

   always_comb begin
      total = SUM_W'(win.up) + SUM_W'(win.down) + SUM_W'(win.left) + SUM_W'(win.right)
            - (SUM_W'(win.ctr) <<< 2);
      // floor((t + 2) / 4): round to nearest, ties up
      quot = (total + SUM_W'(2)) >>> 2;
      if (quot > SUM_W'(32'sh7fff_ffff)) begin
         value = 32'sh7fff_ffff;
      end else if (quot < -SUM_W'(33'sh0_8000_0000)) begin
         value = 32'sh8000_0000;
      end else begin
         value = quot[DATA_W-1:0];
      end
   end

endmodule
